### src/lstep_pkg.sv
`default_nettype none

package lstep_pkg;

	localparam int ROW_BITS   = 64;
	localparam int COUNT_BITS = 7;
	localparam int WIDTH_BITS = 7;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic {
		CFG_MODE  = 1'b0,
		CFG_WIDTH = 1'b1
	} cfg_index_t;

	typedef enum logic {
		NBR_MOORE      = 1'b0,
		NBR_VON_NEUMANN = 1'b1
	} nbr_mode_t;

	typedef enum logic [1:0] {
		JOB_END_ONLY = 2'd0,
		JOB_PASS     = 2'd1,
		JOB_STEP     = 2'd2
	} job_kind_t;

	typedef enum logic [1:0] {
		POS_TOP    = 2'd0,
		POS_SECOND = 2'd1,
		POS_MIDDLE = 2'd2
	} frame_pos_t;

endpackage

`default_nettype wire

### src/lstep_in_if.sv
`default_nettype none

interface lstep_in_if;
	logic                          valid;
	logic                          ready;
	logic [lstep_pkg::ROW_BITS-1:0] row_cells;
	logic                          final_row;

	modport source(output valid, output row_cells, output final_row, input ready);
	modport sink(input valid, input row_cells, input final_row, output ready);
endinterface

`default_nettype wire

### src/lstep_out_if.sv
`default_nettype none

interface lstep_out_if;
	logic                            valid;
	logic                            ready;
	logic [lstep_pkg::ROW_BITS-1:0]   next_row_cells;
	logic [lstep_pkg::COUNT_BITS-1:0] row_alive_count;
	logic                            frame_end;
	logic                            grid_changed;

	modport source(output valid, output next_row_cells, output row_alive_count,
		output frame_end, output grid_changed, input ready);
	modport sink(input valid, input next_row_cells, input row_alive_count,
		input frame_end, input grid_changed, output ready);
endinterface

`default_nettype wire

### src/lstep_front.sv
`default_nettype none

module lstep_front #(
	parameter int MAX_WIDTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lstep_in_if.sink                    rows_in,
	input  wire logic [MAX_WIDTH-1:0]   mask,
	input  wire logic                   push_ready,
	output logic                        push_valid,
	output lstep_pkg::job_kind_t        push_kind,
	output logic                        push_last,
	output logic [MAX_WIDTH-1:0]        push_up,
	output logic [MAX_WIDTH-1:0]        push_mid,
	output logic [MAX_WIDTH-1:0]        push_down
);

	lstep_pkg::frame_pos_t pos_q;
	logic [MAX_WIDTH-1:0]  prev_q;
	logic [MAX_WIDTH-1:0]  prev2_q;
	logic [MAX_WIDTH-1:0]  row_m;
	logic                  accept;

	assign rows_in.ready = push_ready;
	assign accept        = rows_in.valid && push_ready;
	assign row_m         = rows_in.row_cells[MAX_WIDTH-1:0] & mask;

	always_comb begin
		case (pos_q)
			lstep_pkg::POS_TOP:    push_kind = lstep_pkg::JOB_END_ONLY;
			lstep_pkg::POS_SECOND: push_kind = lstep_pkg::JOB_PASS;
			lstep_pkg::POS_MIDDLE: push_kind = lstep_pkg::JOB_STEP;
			default:               push_kind = lstep_pkg::JOB_PASS;
		endcase
	end

	assign push_valid = accept && ((pos_q != lstep_pkg::POS_TOP) || rows_in.final_row);
	assign push_last  = rows_in.final_row;
	assign push_up    = prev2_q & mask;
	assign push_mid   = prev_q & mask;
	assign push_down  = row_m;

	// hold the two rows above the incoming one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= lstep_pkg::POS_TOP;
			prev_q  <= '0;
			prev2_q <= '0;
		end else if (accept) begin
			if (rows_in.final_row) begin
				pos_q   <= lstep_pkg::POS_TOP;
				prev_q  <= '0;
				prev2_q <= '0;
			end else if (pos_q == lstep_pkg::POS_TOP) begin
				pos_q  <= lstep_pkg::POS_SECOND;
				prev_q <= row_m;
			end else begin
				pos_q   <= lstep_pkg::POS_MIDDLE;
				prev2_q <= prev_q;
				prev_q  <= row_m;
			end
		end
	end

endmodule

`default_nettype wire

### src/lstep_queue.sv
`default_nettype none

module lstep_queue #(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   push_ready,
	input  wire logic              pop,
	output logic                   head_valid,
	output logic [DATA_W-1:0]      head_data
);

	localparam int DEPTH = lstep_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

### src/lstep_back.sv
`default_nettype none

module lstep_back #(
	parameter int MAX_WIDTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 mode,
	input  wire logic [MAX_WIDTH-1:0] mask,
	input  wire logic                 head_valid,
	input  wire logic [2+1+3*MAX_WIDTH-1:0] head_data,
	output logic                      pop,
	lstep_out_if.source               rows_out
);

	localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
	localparam int GROUPS = (MAX_WIDTH + 7) / 8;
	localparam int PAD_W  = GROUPS * 8;

	function automatic logic [CNT_W-1:0] pop_count(input logic [MAX_WIDTH-1:0] v);
		logic [PAD_W-1:0] pad;
		logic [3:0]       grp;
		logic [CNT_W-1:0] sum;
		pad = PAD_W'(v);
		sum = '0;
		for (int g = 0; g < GROUPS; g++) begin
			grp = '0;
			for (int b = 0; b < 8; b++) begin
				grp = grp + 4'(pad[g*8+b]);
			end
			sum = sum + CNT_W'(grp);
		end
		return sum;
	endfunction

	lstep_pkg::job_kind_t kind;
	logic                 last;
	logic [MAX_WIDTH-1:0] up;
	logic [MAX_WIDTH-1:0] mid;
	logic [MAX_WIDTH-1:0] down;
	logic [MAX_WIDTH-1:0] nx;
	logic [MAX_WIDTH-1:0] res_row;
	logic                 res_end;
	logic                 res_chg;
	logic                 phase_q;
	logic                 change_q;
	logic                 two_res;
	logic                 final_phase;
	logic                 fire;
	logic                 changed_now;
	logic                 adv_s1;
	logic                 ready_s2;

	logic                 valid_s1;
	logic [MAX_WIDTH-1:0] row_s1;
	logic                 end_s1;
	logic                 chg_s1;

	logic                 valid_s2;
	logic [MAX_WIDTH-1:0] row_s2;
	logic [CNT_W-1:0]     cnt_s2;
	logic                 end_s2;
	logic                 chg_s2;

	assign kind = lstep_pkg::job_kind_t'(head_data[3*MAX_WIDTH+2:3*MAX_WIDTH+1]);
	assign last = head_data[3*MAX_WIDTH];
	assign up   = head_data[3*MAX_WIDTH-1:2*MAX_WIDTH];
	assign mid  = head_data[2*MAX_WIDTH-1:MAX_WIDTH];
	assign down = head_data[MAX_WIDTH-1:0];

	// next generation of the middle row
	always_comb begin
		logic [MAX_WIDTH-1:0] ul, ur, ml, mr, dl, dr;
		logic [3:0]           n;
		ul = up << 1;
		ur = up >> 1;
		ml = mid << 1;
		mr = mid >> 1;
		dl = down << 1;
		dr = down >> 1;
		for (int c = 0; c < MAX_WIDTH; c++) begin
			n = 4'(up[c]) + 4'(down[c]) + 4'(ml[c]) + 4'(mr[c]);
			if (mode == lstep_pkg::NBR_MOORE) begin
				n = n + 4'(ul[c]) + 4'(ur[c]) + 4'(dl[c]) + 4'(dr[c]);
			end
			nx[c] = mask[c] & ((n == 4'd3) | ((n == 4'd2) & mid[c]));
		end
	end

	assign two_res     = (kind != lstep_pkg::JOB_END_ONLY) && last;
	assign final_phase = !two_res || phase_q;
	assign ready_s2    = !valid_s2 || rows_out.ready;
	assign adv_s1      = !valid_s1 || ready_s2;
	assign fire        = head_valid && adv_s1;
	assign pop         = fire && final_phase;
	assign changed_now = !phase_q && (kind == lstep_pkg::JOB_STEP) && (nx != mid);

	always_comb begin
		res_row = mid;
		res_end = 1'b0;
		res_chg = 1'b0;
		if (phase_q) begin
			res_row = down;
			res_end = 1'b1;
			res_chg = change_q;
		end else begin
			case (kind)
				lstep_pkg::JOB_END_ONLY: begin
					res_row = down;
					res_end = 1'b1;
				end
				lstep_pkg::JOB_PASS: res_row = mid;
				lstep_pkg::JOB_STEP: res_row = nx;
				default:             res_row = mid;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			change_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= !final_phase;
				if (res_end) begin
					change_q <= 1'b0;
				end else if (changed_now) begin
					change_q <= 1'b1;
				end
			end
			if (adv_s1) begin
				valid_s1 <= fire;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			row_s1 <= res_row;
			end_s1 <= res_end;
			chg_s1 <= res_chg;
		end
		if (ready_s2 && valid_s1) begin
			row_s2 <= row_s1;
			cnt_s2 <= pop_count(row_s1);
			end_s2 <= end_s1;
			chg_s2 <= chg_s1;
		end
	end

	always_comb begin
		rows_out.valid           = valid_s2;
		rows_out.next_row_cells  = '0;
		rows_out.next_row_cells[MAX_WIDTH-1:0] = row_s2;
		rows_out.row_alive_count = '0;
		rows_out.row_alive_count[CNT_W-1:0]    = cnt_s2;
		rows_out.frame_end       = end_s2;
		rows_out.grid_changed    = chg_s2;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid)
		else $error("bottom row request lost between results");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_end) |=> !change_q)
		else $error("change flag survives frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !end_s2) |-> !chg_s2)
		else $error("change flag outside frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 <= CNT_W'(MAX_WIDTH)))
		else $error("live count above row width");

endmodule

`default_nettype wire

### src/life_automaton_row_step_top.sv
// channel    dir  payload                                              handshake
// rows_in    in   row_cells[63:0], final_row                           valid/ready
// rows_out   out  next_row_cells[63:0], row_alive_count[6:0],          valid/ready
//                 frame_end, grid_changed
// cfg        in   cfg_addr (0 mode, 1 width), cfg_wdata[6:0]           cfg_we
//
// One row per cycle in and out while the row queue has room and the output is
// ready; a bottom row that closes a frame of two or more rows gives two results
// and holds the back end until both are issued. Each result passes through stage
// registers s1 and s2 (the output register); the bottom row follows the other.
// The input side stalls only when the four-entry row queue is full.
// Reset clears frame state and sets Moore mode, width 64; no clearing pass.
`default_nettype none

module life_automaton_row_step_top #(
	parameter int MAX_WIDTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	lstep_in_if.sink                              rows_in,
	lstep_out_if.source                           rows_out,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_addr,
	input  wire logic [lstep_pkg::WIDTH_BITS-1:0] cfg_wdata
);

	localparam int ENTRY_W = 2 + 1 + 3 * MAX_WIDTH;

	logic                                mode_q;
	logic [lstep_pkg::WIDTH_BITS-1:0]    width_q;
	logic [MAX_WIDTH-1:0]                mask;
	logic                                push_valid;
	logic                                push_ready;
	lstep_pkg::job_kind_t                push_kind;
	logic                                push_last;
	logic [MAX_WIDTH-1:0]                push_up;
	logic [MAX_WIDTH-1:0]                push_mid;
	logic [MAX_WIDTH-1:0]                push_down;
	logic                                head_valid;
	logic [ENTRY_W-1:0]                  head_data;
	logic                                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lstep_pkg::NBR_MOORE;
			width_q <= lstep_pkg::WIDTH_BITS'(64);
		end else if (cfg_we) begin
			case (lstep_pkg::cfg_index_t'(cfg_addr))
				lstep_pkg::CFG_MODE:  mode_q  <= cfg_wdata[0];
				lstep_pkg::CFG_WIDTH: width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a width of zero acts as one column
	always_comb begin
		for (int c = 0; c < MAX_WIDTH; c++) begin
			mask[c] = (lstep_pkg::WIDTH_BITS'(c) < width_q) || (c == 0);
		end
	end

	lstep_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows_in   (rows_in),
		.mask      (mask),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_kind (push_kind),
		.push_last (push_last),
		.push_up   (push_up),
		.push_mid  (push_mid),
		.push_down (push_down)
	);

	lstep_queue #(
		.DATA_W(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data ({push_kind, push_last, push_up, push_mid, push_down}),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	lstep_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.mask      (mask),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.rows_out  (rows_out)
	);

endmodule

`default_nettype wire
